@@ rtl/ookd_pkg.sv @@
// Shared types, register codes and reset values for the OOK pulse-width decoder.
package ookd_pkg;

	localparam int ROW_LEN_DEF   = 64;
	localparam int ROW_COUNT_DEF = 8;

	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = 2;
	localparam int OUT_CNT_W = 3;

	localparam logic [15:0] MIN_HIGH_RST   = 16'd200;
	localparam logic [15:0] MIN_PERIOD_RST = 16'd1000;
	localparam logic [15:0] ONE_LIMIT_RST  = 16'd1100;
	localparam logic [15:0] ILLEGAL_RST    = 16'd1200;
	localparam logic [15:0] ZERO_LIMIT_RST = 16'd3150;
	localparam logic [15:0] END_GAP_RST    = 16'd20000;

	typedef enum logic [2:0] {
		CFG_MIN_HIGH   = 3'd0,
		CFG_MIN_PERIOD = 3'd1,
		CFG_ONE_LIMIT  = 3'd2,
		CFG_ILLEGAL    = 3'd3,
		CFG_ZERO_LIMIT = 3'd4,
		CFG_END_GAP    = 3'd5
	} cfg_idx_t;

	localparam logic [1:0] SYM_ZERO = 2'd0;
	localparam logic [1:0] SYM_ONE  = 2'd1;
	localparam logic [1:0] SYM_GAP  = 2'd2;
	localparam logic [1:0] SYM_FULL = 2'd3;

	typedef struct packed {
		logic [15:0] min_high;
		logic [15:0] min_period;
		logic [15:0] one_limit;
		logic [15:0] illegal_limit;
		logic [15:0] zero_limit;
		logic [15:0] end_gap;
	} cfg_t;

	typedef struct packed {
		logic [1:0] symbol;
		logic [7:0] position;
		logic [7:0] row;
		logic       last;
	} result_t;

	// Results of one decoded event; second is only valid when first is.
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_t;

endpackage

@@ rtl/ookd_cfg_regs.sv @@
// Configuration register file of the OOK pulse-width decoder.
module ookd_cfg_regs
	import ookd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_high      <= MIN_HIGH_RST;
			cfg_q.min_period    <= MIN_PERIOD_RST;
			cfg_q.one_limit     <= ONE_LIMIT_RST;
			cfg_q.illegal_limit <= ILLEGAL_RST;
			cfg_q.zero_limit    <= ZERO_LIMIT_RST;
			cfg_q.end_gap       <= END_GAP_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN_HIGH:   cfg_q.min_high      <= cfg_data;
				CFG_MIN_PERIOD: cfg_q.min_period    <= cfg_data;
				CFG_ONE_LIMIT:  cfg_q.one_limit     <= cfg_data;
				CFG_ILLEGAL:    cfg_q.illegal_limit <= cfg_data;
				CFG_ZERO_LIMIT: cfg_q.zero_limit    <= cfg_data;
				CFG_END_GAP:    cfg_q.end_gap       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/ookd_decode.sv @@
// Edge timing state, pulse classification and row bookkeeping.
module ookd_decode
	import ookd_pkg::*;
#(
	parameter int ROW_LEN   = ROW_LEN_DEF,
	parameter int ROW_COUNT = ROW_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        fire,
	input  logic        action,
	input  logic        level,
	input  logic [15:0] stamp,
	output push_t       push
);

	localparam logic [7:0] LEN_M1 = 8'(ROW_LEN - 1);
	localparam logic [8:0] ROWS   = 9'(ROW_COUNT);

	logic        line_q, first_q;
	logic [15:0] rise_q, fall_q, high_q;
	logic [7:0]  fill_q, ptr_q;

	logic        line_n, first_n;
	logic [15:0] rise_n, fall_n, high_n;
	logic [7:0]  fill_n, ptr_n;

	logic        judge, bit_v, gap_v, last_a;
	logic [1:0]  bit_sym, sym_a, sym_g;
	logic [15:0] low_time, period;
	logic [7:0]  fc_a, row_a, fc_g, row_g, fill_mid, ptr_mid;
	logic [8:0]  inc_a, inc_g;

	always_comb begin
		line_n   = line_q;
		first_n  = first_q;
		rise_n   = rise_q;
		fall_n   = fall_q;
		high_n   = high_q;
		judge    = 1'b0;
		low_time = stamp - fall_q;
		period   = cfg.end_gap;
		if (fire) begin
			if (action) begin
				judge   = !first_q && (high_q > cfg.min_high);
				first_n = 1'b1;
			end else if (level) begin
				if (!line_q) begin
					line_n  = 1'b1;
					rise_n  = stamp;
					period  = high_q + low_time;
					judge   = !first_q && (high_q > cfg.min_high) &&
						(period > cfg.min_period);
					first_n = 1'b0;
				end
			end else if (line_q) begin
				line_n = 1'b0;
				fall_n = stamp;
				high_n = stamp - rise_q;
			end
		end

		// Width tests run in a fixed order and the first that holds wins.
		bit_v   = 1'b0;
		bit_sym = SYM_ZERO;
		if (high_q < cfg.min_high) begin
			bit_v = 1'b0;
		end else if (high_q < cfg.one_limit) begin
			bit_v   = 1'b1;
			bit_sym = SYM_ONE;
		end else if (high_q < cfg.illegal_limit) begin
			bit_v = 1'b0;
		end else if (high_q < cfg.zero_limit) begin
			bit_v   = 1'b1;
			bit_sym = SYM_ZERO;
		end
		bit_v = bit_v && judge;
		gap_v = judge && (period >= cfg.end_gap);

		// Bit symbol; a bit that fills the row turns into the full-row end.
		fc_a   = fill_q + 8'd1;
		inc_a  = {1'b0, ptr_q} + 9'd1;
		row_a  = (inc_a >= ROWS) ? 8'd0 : inc_a[7:0];
		sym_a  = (fc_a == LEN_M1) ? SYM_FULL : bit_sym;
		last_a = (sym_a == SYM_FULL);

		fill_mid = fill_q;
		ptr_mid  = ptr_q;
		if (bit_v) begin
			fill_mid = last_a ? 8'd0 : fc_a;
			ptr_mid  = last_a ? row_a : ptr_q;
		end

		// Gap symbol follows the bit, in the row left by the bit.
		fc_g  = fill_mid + 8'd1;
		inc_g = {1'b0, ptr_mid} + 9'd1;
		row_g = (inc_g >= ROWS) ? 8'd0 : inc_g[7:0];
		sym_g = (fc_g == LEN_M1) ? SYM_FULL : SYM_GAP;

		fill_n = gap_v ? 8'd0 : fill_mid;
		ptr_n  = gap_v ? row_g : ptr_mid;

		push.v0 = bit_v || gap_v;
		push.v1 = bit_v && gap_v;
		push.r1 = '{symbol: sym_g, position: fc_g, row: row_g, last: 1'b1};
		if (bit_v) begin
			push.r0 = '{symbol: sym_a, position: fc_a, row: row_a, last: last_a};
		end else begin
			push.r0 = push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q  <= 1'b0;
			first_q <= 1'b1;
			rise_q  <= '0;
			fall_q  <= '0;
			high_q  <= '0;
			fill_q  <= '0;
			ptr_q   <= '0;
		end else begin
			line_q  <= line_n;
			first_q <= first_n;
			rise_q  <= rise_n;
			fall_q  <= fall_n;
			high_q  <= high_n;
			fill_q  <= fill_n;
			ptr_q   <= ptr_n;
		end
	end

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0 && push.r1.last)
		else $error("second result without first, or not a sequence end");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, ptr_q} < ROWS)
		else $error("row pointer beyond row count");

endmodule

@@ rtl/ookd_out_fifo.sv @@
// Four-entry result queue that takes up to two results per cycle.
module ookd_out_fifo
	import ookd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t head
);

	localparam logic [OUT_CNT_W-1:0] DEPTH = OUT_CNT_W'(OUT_DEPTH);

	result_t               mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]  wp_q, rp_q;
	logic [OUT_CNT_W-1:0]  cnt_q;
	logic [OUT_CNT_W-1:0]  n_push;
	logic                  pop;

	assign n_push    = OUT_CNT_W'(push.v0) + OUT_CNT_W'(push.v1);
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rp_q];
	// Room for a full pair of results regardless of this cycle's pop.
	assign room      = (cnt_q <= DEPTH - OUT_CNT_W'(2));

	always_ff @(posedge clk) begin
		if (push.v0) mem_q[wp_q] <= push.r0;
		if (push.v1) mem_q[wp_q + OUT_PTR_W'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + n_push[OUT_PTR_W-1:0];
			rp_q  <= rp_q + OUT_PTR_W'(pop);
			cnt_q <= cnt_q + n_push - OUT_CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 |-> cnt_q + n_push <= DEPTH)
		else $error("result queue overflow");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH)
		else $error("result count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		!push.v0 && !pop |=> $stable(cnt_q))
		else $error("result count moved without push or pop");

endmodule

@@ rtl/ook_pulse_width_decoder.sv @@
// Top level of the OOK pulse-width decoder: input register, decoder and result queue.
//
// Input beats (action, level, stamp) arrive on in_valid/in_ready; each one is a
// line edge or a pulse timeout. Result beats (symbol, position, row, last) leave
// on out_valid/out_ready. Configuration registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is idle,
// which the block itself does not enforce; indexes past the list are ignored.
// An accepted beat is held in an input register, decoded from it once the queue
// has room and written into a four-entry result queue, which offers the results
// in order. One input beat is taken per cycle while the queue has room. An event
// that yields two results (a bit followed by a sequence end) sends them one at a
// time through the single output port of the queue, so that port sets the rate.
// When the receiver stalls, the queue fills; the input register decodes only
// while the queue has room for two results, and in_ready falls once it holds.
// Reset clears the line state, the row bookkeeping and the queue, and loads the
// default timing limits; no clearing pass is needed.
module ook_pulse_width_decoder
	import ookd_pkg::*;
#(
	parameter int ROW_LEN   = ROW_LEN_DEF,
	parameter int ROW_COUNT = ROW_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic        level,
	input  logic [15:0] stamp,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  symbol,
	output logic [7:0]  position,
	output logic [7:0]  row,
	output logic        last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t        cfg;
	push_t       push;
	result_t     head;
	logic        room, fire;
	logic        valid_s1, action_s1, level_s1;
	logic [15:0] stamp_s1;

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			level_s1  <= level;
			stamp_s1  <= stamp;
		end
	end

	ookd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ookd_decode #(
		.ROW_LEN   (ROW_LEN),
		.ROW_COUNT (ROW_COUNT)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.action (action_s1),
		.level  (level_s1),
		.stamp  (stamp_s1),
		.push   (push)
	);

	ookd_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign symbol   = head.symbol;
	assign position = head.position;
	assign row      = head.row;
	assign last     = head.last;

endmodule
